/* hw/rtl/simeck64_128_block_decrypt_assert.svh */
// Assertion macros for the Simeck64/128 decrypt block.
// Needs nothing else; modules that check themselves include this header.
`ifndef SIMECK64_128_BLOCK_DECRYPT_ASSERT_SVH
`define SIMECK64_128_BLOCK_DECRYPT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SIMECK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SIMECK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/simeck_pkg.sv */
// Shared constants, types and the sequencer state for the Simeck64/128 decrypt block.
// Depends on nothing; each RTL module of the block refers to it by scoped names.
`default_nettype none

package simeck_pkg;

    localparam int WORD_W      = 32;
    localparam int ROUND_COUNT = 44;
    localparam int ROUND_W     = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_W       = 2;
    localparam int CFG_INDEX_W = 4;

    localparam logic [WORD_W-1:0] RC_BASE     = 32'hFFFF_FFFC;
    localparam logic [43:0]       RC_SEQUENCE = 44'h938_BCA3_083F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               we;
        logic [ROUND_W-1:0] waddr;
        logic [WORD_W-1:0]  wdata;
        logic [ROUND_W-1:0] raddr;
    } key_store_req_t;

endpackage

`default_nettype wire

/* hw/rtl/simeck_mix.sv */
// Round function f(x) = (x AND rotl5 x) XOR rotl1 x, shared by key expansion and rounds.
// Depends on simeck_pkg for the word width.
`default_nettype none

module simeck_mix (
    input  wire logic [simeck_pkg::WORD_W-1:0] x,
    output logic      [simeck_pkg::WORD_W-1:0] y
);

    logic [simeck_pkg::WORD_W-1:0] rot1;
    logic [simeck_pkg::WORD_W-1:0] rot5;

    assign rot1 = {x[simeck_pkg::WORD_W-2:0], x[simeck_pkg::WORD_W-1]};
    assign rot5 = {x[simeck_pkg::WORD_W-6:0], x[simeck_pkg::WORD_W-1 -: 5]};
    assign y    = (x & rot5) ^ rot1;

endmodule

`default_nettype wire

/* hw/rtl/simeck_key_store.sv */
// Round key memory: one write port, one read port with registered read data.
// Depends on simeck_pkg for depth, widths and the request struct.
`default_nettype none

module simeck_key_store (
    input  wire logic                           clk,
    input  wire simeck_pkg::key_store_req_t     req,
    output logic      [simeck_pkg::WORD_W-1:0]  rd_data
);

    logic [simeck_pkg::WORD_W-1:0] mem [simeck_pkg::ROUND_COUNT];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/simeck64_128_block_decrypt.sv */
// Simeck64/128 block decryption: sequencer, key and block registers, output register.
// Depends on simeck_pkg, simeck_mix, simeck_key_store and the assertion header.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   cfg     | cfg_we, cfg_index, cfg_data               | in
//   in      | in_valid, in_ready, cipher_right/left     | in
//   out     | out_valid, out_ready, plain_right/left    | out
//
// A block runs 44 rounds, one round per cycle, through the single mix unit, each reading
// its round key from the key memory's one read port.
// After reset or a key write the first block first runs key expansion in ST_FILL, all 44
// round keys through the same mix unit, writing one round key a cycle, then ST_LOAD primes the read.
// in_ready is high only while no block is in work; the output register frees the next
// block to start while a result waits. A block that finishes while the output register is
// still full waits in ST_DONE until the register frees.
`default_nettype none

`include "simeck64_128_block_decrypt_assert.svh"

module simeck64_128_block_decrypt (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [simeck_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [simeck_pkg::WORD_W-1:0]       cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [simeck_pkg::WORD_W-1:0]       cipher_right,
    input  wire logic [simeck_pkg::WORD_W-1:0]       cipher_left,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [simeck_pkg::WORD_W-1:0]       plain_right,
    output logic      [simeck_pkg::WORD_W-1:0]       plain_left
);

    localparam logic [simeck_pkg::ROUND_W-1:0] LAST =
        simeck_pkg::ROUND_W'(simeck_pkg::ROUND_COUNT - 1);

    simeck_pkg::state_t state_reg, state_next;

    logic [simeck_pkg::ROUND_W-1:0] cnt_reg, cnt_next;
    logic                           stale_reg, stale_next;
    logic                           out_valid_reg, out_valid_next;
    logic [simeck_pkg::WORD_W-1:0]  key_word_reg [simeck_pkg::KEY_WORDS];

    logic [simeck_pkg::WORD_W-1:0]  k0_reg, k1_reg, k2_reg, k3_reg;
    logic [simeck_pkg::WORD_W-1:0]  k0_next, k1_next, k2_next, k3_next;
    logic [simeck_pkg::WORD_W-1:0]  left_reg, right_reg, left_next, right_next;
    logic [simeck_pkg::WORD_W-1:0]  pl_reg, pr_reg, pl_next, pr_next;

    logic [simeck_pkg::WORD_W-1:0]  mix_in, mix_out, round_key, rc, new_right;
    logic                           key_write, in_accept, slot_free;
    simeck_pkg::key_store_req_t     store_req;

    simeck_mix u_mix (
        .x (mix_in),
        .y (mix_out)
    );

    simeck_key_store u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (round_key)
    );

    assign key_write = cfg_we && (cfg_index < simeck_pkg::CFG_INDEX_W'(simeck_pkg::KEY_WORDS));
    assign in_ready  = (state_reg == simeck_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign rc        = simeck_pkg::RC_BASE | simeck_pkg::WORD_W'(simeck_pkg::RC_SEQUENCE[cnt_reg]);
    assign mix_in    = (state_reg == simeck_pkg::ST_FILL) ? k1_reg : right_reg;
    assign new_right = mix_out ^ left_reg ^ round_key;

    assign out_valid   = out_valid_reg;
    assign plain_right = pr_reg;
    assign plain_left  = pl_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        stale_next      = stale_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        k0_next         = k0_reg;
        k1_next         = k1_reg;
        k2_next         = k2_reg;
        k3_next         = k3_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        pl_next         = pl_reg;
        pr_next         = pr_reg;
        store_req.we    = 1'b0;
        store_req.waddr = cnt_reg;
        store_req.wdata = k0_reg;
        store_req.raddr = LAST;

        case (state_reg)
            simeck_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    left_next  = cipher_left;
                    right_next = cipher_right;
                    k0_next    = key_word_reg[0];
                    k1_next    = key_word_reg[1];
                    k2_next    = key_word_reg[2];
                    k3_next    = key_word_reg[3];
                    if (stale_reg)
                    begin
                        cnt_next   = '0;
                        state_next = simeck_pkg::ST_FILL;
                    end
                    else
                    begin
                        cnt_next   = LAST;
                        state_next = simeck_pkg::ST_RUN;
                    end
                end
            end
            simeck_pkg::ST_FILL:
            begin
                store_req.we = 1'b1;
                k0_next      = k1_reg;
                k1_next      = k2_reg;
                k2_next      = k3_reg;
                k3_next      = mix_out ^ k0_reg ^ rc;
                if (cnt_reg == LAST)
                begin
                    stale_next = 1'b0;
                    state_next = simeck_pkg::ST_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + simeck_pkg::ROUND_W'(1);
                end
            end
            simeck_pkg::ST_LOAD:
            begin
                cnt_next   = LAST;
                state_next = simeck_pkg::ST_RUN;
            end
            simeck_pkg::ST_RUN:
            begin
                if (cnt_reg != '0)
                begin
                    store_req.raddr = cnt_reg - simeck_pkg::ROUND_W'(1);
                    left_next       = right_reg;
                    right_next      = new_right;
                    cnt_next        = cnt_reg - simeck_pkg::ROUND_W'(1);
                end
                else if (slot_free)
                begin
                    pl_next        = right_reg;
                    pr_next        = new_right;
                    out_valid_next = 1'b1;
                    state_next     = simeck_pkg::ST_IDLE;
                end
                else
                begin
                    left_next  = right_reg;
                    right_next = new_right;
                    state_next = simeck_pkg::ST_DONE;
                end
            end
            simeck_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    pl_next        = left_reg;
                    pr_next        = right_reg;
                    out_valid_next = 1'b1;
                    state_next     = simeck_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = simeck_pkg::ST_IDLE;
            end
        endcase

        if (key_write)
        begin
            stale_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= simeck_pkg::ST_IDLE;
            cnt_reg         <= '0;
            stale_reg       <= 1'b1;
            out_valid_reg   <= 1'b0;
            key_word_reg[0] <= '0;
            key_word_reg[1] <= '0;
            key_word_reg[2] <= '0;
            key_word_reg[3] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            stale_reg     <= stale_next;
            out_valid_reg <= out_valid_next;
            if (key_write)
            begin
                key_word_reg[cfg_index[simeck_pkg::KEY_W-1:0]] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k0_reg    <= k0_next;
        k1_reg    <= k1_next;
        k2_reg    <= k2_next;
        k3_reg    <= k3_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        pl_reg    <= pl_next;
        pr_reg    <= pr_next;
    end

    `SIMECK_ASSERT_NEXT(a_stale_fills, clk, rst_n, in_accept && stale_reg,
        state_reg == simeck_pkg::ST_FILL, "stale keys did not start expansion")
    `SIMECK_ASSERT_NEXT(a_fresh_runs, clk, rst_n, in_accept && !stale_reg,
        state_reg == simeck_pkg::ST_RUN && cnt_reg == LAST, "fresh keys did not start rounds")
    `SIMECK_ASSERT_SAME(a_fill_stale, clk, rst_n, state_reg == simeck_pkg::ST_FILL,
        stale_reg, "key expansion running with fresh store")
    `SIMECK_ASSERT_SAME(a_done_held, clk, rst_n, state_reg == simeck_pkg::ST_DONE,
        out_valid_reg, "result held back with empty output register")

endmodule

`default_nettype wire

/* tb/simeck64_128_block_decrypt_tb.sv */
// Self-checking bench for simeck64_128_block_decrypt: random and directed blocks under several keys.
// Carries its own key schedule and decryption for the expected plaintext.
// Needs simeck_pkg and the block's RTL only.
module simeck64_128_block_decrypt_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import simeck_pkg::*;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t left;
        word_t right;
    } block_t;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = CFG_INDEX_W'(3);

    localparam int PHASES       = 8;
    localparam int PHASE_BLOCKS = 100;
    localparam int STUCK_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 120;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    word_t                  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    word_t                  cipher_right = '0;
    word_t                  cipher_left = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    word_t                  plain_right;
    word_t                  plain_left;

    word_t  key_model [KEY_WORDS];
    word_t  sched_key [ROUND_COUNT];
    bit     keys_stale = 1'b1;

    block_t pending_blocks [$];
    block_t plain_expected [$];

    bit     block_taken = 1'b0;
    bit     send_idling = 1'b1;
    bit     recv_idling = 1'b1;
    int     send_gap = 0;
    int     recv_gap = 0;
    int     errors = 0;
    int     blocks_sent = 0;
    int     results_checked = 0;
    int     key_loads = 0;
    int     ignored_writes = 0;
    int     stuck_cycles = 0;
    block_t next_block;
    block_t want;

    simeck64_128_block_decrypt i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cipher_right (cipher_right),
        .cipher_left  (cipher_left),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .plain_right  (plain_right),
        .plain_left   (plain_left)
    );

    always #1 clk = ~clk;

    function automatic word_t rotl(word_t v, int unsigned s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic word_t feistel_mix(word_t v);
        return (v & rotl(v, 5)) ^ rotl(v, 1);
    endfunction

    function automatic void expand_round_keys();
        word_t k [KEY_WORDS];
        word_t rc;
        word_t nk;
        for (int i = 0; i < KEY_WORDS; i++)
            k[i] = key_model[i];
        for (int r = 0; r < ROUND_COUNT; r++)
        begin
            rc = RC_BASE | word_t'(RC_SEQUENCE[r]);
            sched_key[r] = k[0];
            nk = feistel_mix(k[1]) ^ k[0] ^ rc;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
        end
        keys_stale = 1'b0;
        key_loads++;
    endfunction

    function automatic block_t decrypt_block(block_t c);
        word_t l;
        word_t rr;
        word_t t;
        if (keys_stale)
            expand_round_keys();
        l = c.left;
        rr = c.right;
        for (int r = ROUND_COUNT - 1; r >= 0; r--)
        begin
            t = feistel_mix(rr) ^ l ^ sched_key[r];
            l = rr;
            rr = t;
        end
        return '{left: l, right: rr};
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
            3: return ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, word_t val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx < KEY_WORDS)
        begin
            key_model[idx] = val;
            keys_stale = 1'b1;
        end
        else
            ignored_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_key(word_t k0, word_t k1, word_t k2, word_t k3);
        write_reg(REG_KEY_WORD_0, k0);
        write_reg(REG_KEY_WORD_1, k1);
        write_reg(REG_KEY_WORD_2, k2);
        write_reg(REG_KEY_WORD_3, k3);
    endtask

    task automatic queue_block(word_t right, word_t left);
        pending_blocks.push_back('{left: left, right: right});
    endtask

    task automatic queue_directed();
        queue_block(32'h0000_0000, 32'h0000_0000);
        queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(32'h0000_0000, 32'hFFFF_FFFF);
        queue_block(32'hFFFF_FFFF, 32'h0000_0000);
        queue_block(32'hAAAA_AAAA, 32'h5555_5555);
        queue_block(32'h5555_5555, 32'hAAAA_AAAA);
        queue_block(32'h8000_0000, 32'h0000_0001);
        queue_block(32'h0000_0001, 32'h8000_0000);
        queue_block(32'h5F7A_B7ED, 32'h45CE_6902);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            queue_block(pick_word(), pick_word());
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0 || plain_expected.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // sender: hold the item until it is taken, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || block_taken)
        begin
            block_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_blocks.size() != 0)
            begin
                next_block = pending_blocks.pop_front();
                cipher_right <= next_block.right;
                cipher_left <= next_block.left;
                in_valid <= 1'b1;
                if (send_idling && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (recv_idling && $urandom_range(0, 5) == 0)
                recv_gap = $urandom_range(1, 19);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            block_taken = 1'b1;
            plain_expected.push_back(decrypt_block('{left: cipher_left, right: cipher_right}));
            blocks_sent++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (plain_expected.size() == 0)
            begin
                $error("unexpected item: plain_right %h plain_left %h", plain_right, plain_left);
                errors++;
            end
            else
            begin
                want = plain_expected.pop_front();
                if (plain_right !== want.right)
                begin
                    $error("plain_right: expected %h, actual %h", want.right, plain_right);
                    errors++;
                end
                if (plain_left !== want.left)
                begin
                    $error("plain_left: expected %h, actual %h", want.left, plain_left);
                    errors++;
                end
                results_checked++;
            end
        end
    end

    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("Timed out with %0d results outstanding", plain_expected.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < KEY_WORDS; i++)
            key_model[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset key, then the published test key
        queue_directed();
        drain();
        write_key(32'h0302_0100, 32'h0B0A_0908, 32'h1312_1110, 32'h1B1A_1918);
        queue_directed();
        drain();

        // out-of-range writes must leave the key alone
        for (int i = KEY_WORDS; i < 2 ** CFG_INDEX_W; i++)
            write_reg(CFG_INDEX_W'(i), $urandom);
        queue_block(32'h5F7A_B7ED, 32'h45CE_6902);
        queue_random(3);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_key('0, '0, '0, '0);
                1: write_key('1, '1, '1, '1);
                2: write_key(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
                3: write_reg(CFG_INDEX_W'($urandom_range(0, KEY_WORDS - 1)), $urandom);
                4: write_reg(REG_KEY_WORD_2, key_model[REG_KEY_WORD_2]);
                default: write_key(pick_word(), pick_word(), pick_word(), pick_word());
            endcase
            send_idling = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            recv_idling = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            queue_random(PHASE_BLOCKS / 2);
            if (p == 5)
                drain();
            queue_random(PHASE_BLOCKS - PHASE_BLOCKS / 2);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (plain_expected.size() != 0)
        begin
            $error("%0d results never arrived", plain_expected.size());
            errors++;
        end

        $display("Sent %0d blocks, checked %0d plaintexts over %0d key schedules",
                 blocks_sent, results_checked, key_loads);
        $display("Issued %0d writes to unused register slots", ignored_writes);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
